### rtl/evrr_pkg.sv
// Shared constants, codes and result type of the event-flag dispatcher.
package evrr_pkg;

  localparam int EVRR_MAX_TASKS   = 16;
  localparam int EVRR_EVENT_WIDTH = 16;

  localparam int ACT_W   = 3;
  localparam int TASK_W  = 8;
  localparam int BITS_W  = 16;
  localparam int STAT_W  = 2;
  localparam int GRANT_W = 4;
  localparam int TCNT_W  = 5;

  localparam logic [TCNT_W-1:0] TASK_COUNT_RST = 5'd16;

  localparam logic [ACT_W-1:0] ACT_SET      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MASK     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNMASK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GET      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_IDLE    = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [BITS_W-1:0]  visible_events;
    logic [GRANT_W-1:0] granted_task;
  } res_t;

endpackage

### rtl/evrr_ifc.sv
// Valid/ready channel interfaces for request and result words.
interface evrr_in_if
  import evrr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TASK_W-1:0] task_index;
  logic [BITS_W-1:0] event_bits;

  modport source (output valid, action, task_index, event_bits, input ready);
  modport sink (input valid, action, task_index, event_bits, output ready);
endinterface

interface evrr_out_if
  import evrr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [BITS_W-1:0]  visible_events;
  logic [GRANT_W-1:0] granted_task;

  modport source (output valid, status, visible_events, granted_task, input ready);
  modport sink (input valid, status, visible_events, granted_task, output ready);
endinterface

### rtl/evrr_store.sv
// Per-task pending/mask memory with registered read and reset-cleared valid bits.
module evrr_store
  import evrr_pkg::*;
#(
  parameter int MAX_TASKS   = EVRR_MAX_TASKS,
  parameter int EVENT_WIDTH = EVRR_EVENT_WIDTH,
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [EVENT_WIDTH-1:0] rd_pend,
  output logic [EVENT_WIDTH-1:0] rd_mask,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [EVENT_WIDTH-1:0] wr_pend,
  input  logic [EVENT_WIDTH-1:0] wr_mask
);

  logic [2*EVENT_WIDTH-1:0] mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]     vld_r;
  logic [2*EVENT_WIDTH-1:0] rd_data_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_pend, wr_mask};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_pend = rd_vld_r ? rd_data_r[2*EVENT_WIDTH-1:EVENT_WIDTH] : '0;
  assign rd_mask = rd_vld_r ? rd_data_r[EVENT_WIDTH-1:0] : '0;

endmodule

### rtl/evrr_step.sv
// Shared pointer step unit: increment a task index with wrap at the active count.
module evrr_step
  import evrr_pkg::*;
#(
  parameter int MAX_TASKS = EVRR_MAX_TASKS,
  localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CW  = $clog2(MAX_TASKS + 1),
  localparam int CNW = (CW > TCNT_W) ? CW : TCNT_W
) (
  input  logic [AW-1:0]  cur,
  input  logic [CNW-1:0] count,
  output logic [AW-1:0]  nxt
);

  logic [CNW-1:0] sum;

  assign sum = CNW'(cur) + CNW'(1);
  assign nxt = (sum >= count) ? '0 : AW'(sum);

endmodule

### rtl/evrr_ctrl.sv
// Sequencer: decodes a request word, runs the slot scan and holds the result word.
module evrr_ctrl
  import evrr_pkg::*;
#(
  parameter int MAX_TASKS   = EVRR_MAX_TASKS,
  parameter int EVENT_WIDTH = EVRR_EVENT_WIDTH,
  localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CW  = $clog2(MAX_TASKS + 1),
  localparam int CNW = (CW > TCNT_W) ? CW : TCNT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [TCNT_W-1:0]      task_count,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [TASK_W-1:0]      in_task,
  input  logic [BITS_W-1:0]      in_bits,
  output logic                   out_valid,
  input  logic                   out_ready,
  output res_t                   out_res,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  logic [EVENT_WIDTH-1:0] rd_pend,
  input  logic [EVENT_WIDTH-1:0] rd_mask,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [EVENT_WIDTH-1:0] wr_pend,
  output logic [EVENT_WIDTH-1:0] wr_mask
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [ACT_W-1:0]       act_r, act_nxt;
  logic [EVENT_WIDTH-1:0] bits_r, bits_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [AW-1:0]          q_r, q_nxt;
  logic [CNW-1:0]         iss_r, iss_nxt;
  logic [CNW-1:0]         chk_n_r, chk_n_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]          chk_addr_r, chk_addr_nxt;
  res_t                   res_r, res_nxt;
  res_t                   out_r, out_nxt;
  logic                   out_vld_r, out_vld_nxt;

  logic [CNW-1:0]         cnt;
  logic [EVENT_WIDTH-1:0] visible;
  logic                   found;
  logic [AW-1:0]          step_in, step_out;

  assign cnt = (CNW'(task_count) > CNW'(MAX_TASKS)) ? CNW'(MAX_TASKS) : CNW'(task_count);
  assign visible = rd_pend & ~rd_mask;
  assign found = chk_vld_r && (visible != '0);
  assign step_in = found ? chk_addr_r : q_r;

  evrr_step #(.MAX_TASKS(MAX_TASKS)) u_step (
    .cur   (step_in),
    .count (cnt),
    .nxt   (step_out)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_res   = out_r;
  assign wr_addr   = addr_r;

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    bits_nxt     = bits_r;
    addr_nxt     = addr_r;
    ptr_nxt      = ptr_r;
    q_nxt        = q_r;
    iss_nxt      = iss_r;
    chk_n_nxt    = chk_n_r;
    chk_vld_nxt  = 1'b0;
    chk_addr_nxt = chk_addr_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    rd_en        = 1'b0;
    rd_addr      = addr_r;
    wr_en        = 1'b0;
    wr_pend      = rd_pend;
    wr_mask      = rd_mask;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt  = in_action;
          bits_nxt = EVENT_WIDTH'(in_bits);
          addr_nxt = in_task[AW-1:0];
          res_nxt  = '0;
          if (in_action == ACT_DISPATCH) begin
            q_nxt     = (CNW'(ptr_r) < cnt) ? ptr_r : '0;
            iss_nxt   = '0;
            chk_n_nxt = '0;
            state_nxt = S_SCAN;
          end else if (in_action <= ACT_GET) begin
            if (in_task < TASK_W'(cnt)) begin
              state_nxt = S_RD;
            end else begin
              res_nxt.status = ST_INVALID;
              state_nxt      = S_DONE;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_OP;
      end
      S_OP: begin
        case (act_r)
          ACT_SET: begin
            wr_en   = 1'b1;
            wr_pend = rd_pend | bits_r;
          end
          ACT_CLEAR: begin
            wr_en   = 1'b1;
            wr_pend = rd_pend & ~bits_r;
          end
          ACT_MASK: begin
            wr_en   = 1'b1;
            wr_mask = rd_mask | bits_r;
          end
          ACT_UNMASK: begin
            wr_en   = 1'b1;
            wr_mask = rd_mask & ~bits_r;
          end
          default: begin
            res_nxt.visible_events = BITS_W'(visible);
          end
        endcase
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (found) begin
          res_nxt.granted_task = GRANT_W'(chk_addr_r);
          ptr_nxt              = step_out;
          state_nxt            = S_DONE;
        end else if (!chk_vld_r && (chk_n_r == cnt)) begin
          res_nxt.status = ST_IDLE;
          state_nxt      = S_DONE;
        end else begin
          if (chk_vld_r) begin
            chk_n_nxt = chk_n_r + CNW'(1);
          end
          if (iss_r < cnt) begin
            rd_en        = 1'b1;
            rd_addr      = q_r;
            q_nxt        = step_out;
            iss_nxt      = iss_r + CNW'(1);
            chk_vld_nxt  = 1'b1;
            chk_addr_nxt = q_r;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ptr_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    bits_r     <= bits_nxt;
    addr_r     <= addr_nxt;
    q_r        <= q_nxt;
    iss_r      <= iss_nxt;
    chk_n_r    <= chk_n_nxt;
    chk_addr_r <= chk_addr_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule

### rtl/event_flag_round_robin_dispatcher_core.sv
// Top level: task count register, channel wiring, sequencer and task memory.
// Set/clear/mask/unmask/get pass S_RD, S_OP and S_DONE; invalid or unused words go to S_DONE.
// Dispatch scans one slot per cycle through the shared step unit from the round-robin
// pointer; a hit moves the pointer past the grant, else ST_IDLE; a held result stalls S_DONE.
// Throughput: one word at a time; the next word is taken while a result waits.
// Reset (rst_n low, synchronous): all events and masks read zero, pointer 0, task count 16.
module event_flag_round_robin_dispatcher_core
  import evrr_pkg::*;
#(
  parameter int MAX_TASKS   = EVRR_MAX_TASKS,
  parameter int EVENT_WIDTH = EVRR_EVENT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  evrr_in_if.sink           in_ch,
  evrr_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [TCNT_W-1:0] cfg_wr_data
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [TCNT_W-1:0]      task_count_r;
  res_t                   res;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [EVENT_WIDTH-1:0] rd_pend, rd_mask, wr_pend, wr_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TASK_COUNT_RST;
    end else if (cfg_wr_en) begin
      task_count_r <= cfg_wr_data;
    end
  end

  evrr_ctrl #(.MAX_TASKS(MAX_TASKS), .EVENT_WIDTH(EVENT_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .task_count (task_count_r),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .in_task    (in_ch.task_index),
    .in_bits    (in_ch.event_bits),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    (res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_pend    (rd_pend),
    .rd_mask    (rd_mask),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_pend    (wr_pend),
    .wr_mask    (wr_mask)
  );

  evrr_store #(.MAX_TASKS(MAX_TASKS), .EVENT_WIDTH(EVENT_WIDTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_pend (rd_pend),
    .rd_mask (rd_mask),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_pend (wr_pend),
    .wr_mask (wr_mask)
  );

  assign out_ch.status         = res.status;
  assign out_ch.visible_events = res.visible_events;
  assign out_ch.granted_task   = res.granted_task;

endmodule
